### hw/rtl/triangular_system_solver_defines.svh
// Assertion helpers used by the solver controller.
`ifndef TRIANGULAR_SYSTEM_SOLVER_DEFINES_SVH
`define TRIANGULAR_SYSTEM_SOLVER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TSS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define TSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/tss_pkg.sv
// ---------------------------------------------------------------------------
// tss_pkg
// Types, codes and helpers shared by the triangular solver modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tss_pkg;
    localparam int TSS_MAX_N = 16;

    typedef enum logic [1:0] {
        KIND_MATRIX = 2'd0,
        KIND_VECTOR = 2'd1,
        KIND_SOLVE  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic CFG_SYSTEM_SIZE = 1'b0;
    localparam logic CFG_BACK_SUBST  = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               zero_pivot;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIAG_RD,
        ST_DIAG_WT,
        ST_DIV,
        ST_DIV_WB,
        ST_MAC_RD,
        ST_MAC_WT,
        ST_MAC_MUL,
        ST_MAC_EXE,
        ST_OUT_RD,
        ST_OUT_WT,
        ST_OUT_SEND
    } state_t;

    // Micro-operations issued to the datapath.
    typedef struct packed {
        logic       rd;        // read matrix word (rr,cc) and vector word vi
        logic [5:0] rr;
        logic [5:0] cc;
        logic [5:0] vi;
        logic       acc_clr;   // clear forward running sum
        logic       div_start;
        logic       div_wb;    // write quotient to x[vi]
        logic       mul;       // register product of the read words
        logic       mac_back;  // x[vi] -= product, write back
        logic       mac_fwd;   // t += product
        logic       out_load;  // load output register
        logic [5:0] out_idx;
        logic       out_last;
        logic       fwd_sub;   // divide operand is sat(x - t)
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -34'sh080000000) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

### hw/rtl/triangular_system_solver.sv
// ---------------------------------------------------------------------------
// triangular_system_solver
// Q16.16 upper triangular solver, back or forward substitution in place.
// ---------------------------------------------------------------------------
// Channel   Direction  Content
// s_        in         load matrix entry, load right side, or solve
// m_        out        solution elements in index order, last on the final
// cfg_      in         register index and write data
//
// Loads are written as they are accepted, so they can follow back to back. A
// solve of size n runs n(n-1)/2 multiply-accumulates and n divisions (in the
// bit-serial divider), then sends n results.
// Reset clears only control state; stores are undefined until written.
// A stalled result channel holds the sequencer in its output phase.
`timescale 1ns / 1ps
module triangular_system_solver #(
    parameter int MAX_N = tss_pkg::TSS_MAX_N
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tss_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tss_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import tss_pkg::*;

    logic [4:0] size_reg;
    logic       back_reg;
    logic       idle, acc, ld_mat, ld_vec, solve_start;
    cmd_t       cmd;
    status_t    status;
    logic [6:0] lim;

    // Configuration is accepted at any time; a solve samples both registers
    // when it starts.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 5'd16;
            back_reg <= 1'b1;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SYSTEM_SIZE) size_reg <= cfg_data[4:0];
            else back_reg <= cfg_data[0];
        end
    end

    // Items are taken only while the sequencer is idle.
    assign s_ready     = idle;
    assign acc         = s_valid && s_ready;
    assign lim         = 7'(MAX_N);
    assign ld_mat      = acc && s_data.kind == KIND_MATRIX &&
                         {3'd0, s_data.row} < lim && {3'd0, s_data.col} < lim;
    assign ld_vec      = acc && s_data.kind == KIND_VECTOR && {3'd0, s_data.row} < lim;
    assign solve_start = acc && s_data.kind == KIND_SOLVE;

    tss_controller #(.MAX_N(MAX_N)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .solve_start(solve_start), .size(size_reg),
        .back(back_reg), .status(status), .cmd(cmd), .idle(idle)
    );

    tss_datapath #(.MAX_N(MAX_N)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ld_mat(ld_mat), .ld_vec(ld_vec),
        .ld_item(s_data), .cmd(cmd), .status(status), .m_item(m_data),
        .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule

### hw/rtl/tss_divider.sv
// ---------------------------------------------------------------------------
// tss_divider
// Restoring divider, one quotient bit a cycle, Q16.16 truncating division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quot,
    output logic               zero
);
    import tss_pkg::*;

    logic [47:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic        sgn_reg, sgn_next;
    logic [48:0] trial;
    logic [48:0] mag;
    logic [33:0] sq;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        sgn_next  = sgn_reg;
        trial     = {rem_reg, q_reg[47]} - {17'd0, d_reg};
        if (start) begin
            // Dividend magnitude shifted by 16 lives in the quotient shifter.
            q_next    = {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            rem_next  = '0;
            d_next    = den[31] ? 32'(-den) : 32'(den);
            neg_next  = num[31] ^ den[31];
            zero_next = (den == 0);
            sgn_next  = num[31];
            cnt_next  = 6'd48;
            busy_next = (den != 0);
            if (den == 0) begin
                q_next = (num == 0) ? 48'd0 : 48'd1;
            end
        end else if (busy_reg) begin
            if (!trial[48]) begin
                rem_next = trial[47:0];
                q_next   = {q_reg[46:0], 1'b1};
            end else begin
                rem_next = {rem_reg[46:0], q_reg[47]};
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        sgn_reg  <= sgn_next;
    end

    always_comb begin
        mag = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
        if (mag[48:33] == {16{mag[48]}}) sq = mag[33:0];
        else sq = mag[48] ? -34'sd8589934592 : 34'sd8589934591;
        if (zero_reg) begin
            if (q_reg[0] == 1'b0) quot = '0;
            else quot = sgn_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            quot = sat32(sq);
        end
    end
    assign busy = busy_reg;
    assign zero = zero_reg;
endmodule

### hw/rtl/tss_datapath.sv
// ---------------------------------------------------------------------------
// tss_datapath
// Matrix and vector stores, multiplier, accumulator and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_datapath #(
    parameter int MAX_N = tss_pkg::TSS_MAX_N
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ld_mat,
    input  logic                ld_vec,
    input  tss_pkg::in_item_t   ld_item,
    input  tss_pkg::cmd_t       cmd,
    output tss_pkg::status_t    status,
    output tss_pkg::out_item_t  m_item,
    output logic                m_valid,
    input  logic                m_ready
);
    import tss_pkg::*;
    // Addresses are four bits wide, so the stores never need more than 16 rows.
    localparam int DEPTH = (MAX_N < 16) ? MAX_N : 16;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [31:0] mat_mem [DEPTH][DEPTH];
    logic signed [31:0] vec_mem [DEPTH];
    logic [DEPTH-1:0]   zp_reg;
    logic signed [31:0] a_reg, v_reg, t_reg, p_reg, w_reg;
    logic signed [63:0] prod;
    logic signed [31:0] qm;
    logic signed [31:0] dnum;
    logic signed [31:0] quot;
    logic               dzero, dbusy;
    logic [AW-1:0]      vi, ri, ci, oi;
    logic               wr_en;
    logic [AW-1:0]      wr_a;
    logic signed [31:0] wr_d;
    out_item_t          out_reg;
    logic               ov_reg;

    assign vi = cmd.vi[AW-1:0];
    assign ri = cmd.rr[AW-1:0];
    assign ci = cmd.cc[AW-1:0];
    assign oi = cmd.out_idx[AW-1:0];

    always_ff @(posedge aclk) begin
        if (ld_mat) mat_mem[ld_item.row[AW-1:0]][ld_item.col[AW-1:0]] <= ld_item.value;
        if (cmd.rd) a_reg <= mat_mem[ri][ci];
    end

    always_comb begin
        wr_en = 1'b0;
        wr_a  = ld_item.row[AW-1:0];
        wr_d  = ld_item.value;
        if (ld_vec) begin
            wr_en = 1'b1;
        end else if (cmd.div_wb) begin
            wr_en = 1'b1;
            wr_a  = vi;
            wr_d  = quot;
        end else if (cmd.mac_back) begin
            wr_en = 1'b1;
            wr_a  = vi;
            wr_d  = sat32(34'(v_reg) - 34'(p_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) vec_mem[wr_a] <= wr_d;
        if (cmd.rd) v_reg <= vec_mem[vi];
        if (cmd.out_load) w_reg <= vec_mem[oi];
    end

    assign prod = 64'(a_reg) * 64'(v_reg);
    always_comb begin
        if (prod[63:47] == {17{prod[63]}}) qm = prod[47:16];
        else qm = prod[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) p_reg <= qm;
        if (cmd.acc_clr) t_reg <= '0;
        else if (cmd.mac_fwd) t_reg <= sat32(34'(t_reg) + 34'(p_reg));
        if (cmd.div_wb) zp_reg[vi] <= dzero;
    end

    assign dnum = cmd.fwd_sub ? sat32(34'(v_reg) - 34'(t_reg)) : v_reg;

    tss_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(dnum), .den(a_reg), .busy(dbusy), .quot(quot), .zero(dzero)
    );

    // Output register: loaded in the cycle after the vector read is issued.
    logic load_d_reg, last_d_reg;
    logic [3:0] idx_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg     <= 1'b0;
            load_d_reg <= 1'b0;
        end else begin
            load_d_reg <= cmd.out_load;
            if (load_d_reg) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
        end
        idx_d_reg  <= 4'(cmd.out_idx);
        last_d_reg <= cmd.out_last;
        if (load_d_reg) begin
            out_reg.index      <= idx_d_reg;
            out_reg.solution   <= w_reg;
            out_reg.zero_pivot <= zp_reg[idx_d_reg[AW-1:0]];
            out_reg.last       <= last_d_reg;
        end
    end

    assign m_item          = out_reg;
    assign m_valid         = ov_reg;
    assign status.div_busy = dbusy;
    assign status.out_full = ov_reg | load_d_reg;
endmodule

### hw/rtl/tss_controller.sv
// ---------------------------------------------------------------------------
// tss_controller
// Sequencer for the substitution loops and the result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tss_controller #(
    parameter int MAX_N = tss_pkg::TSS_MAX_N
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              solve_start,
    input  logic [4:0]        size,
    input  logic              back,
    input  tss_pkg::status_t  status,
    output tss_pkg::cmd_t     cmd,
    output logic              idle
);
    import tss_pkg::*;
    `include "triangular_system_solver_defines.svh"

    // A solved system never exceeds sixteen elements, whatever MAX_N is.
    localparam int N_LIM = (MAX_N < 16) ? MAX_N : 16;

    state_t     state_reg, state_next;
    logic [5:0] n_reg, n_next;
    logic [5:0] i_reg, i_next;
    logic [5:0] k_reg, k_next;
    logic       back_reg, back_next;
    logic [5:0] nsel;

    always_comb begin
        nsel = {1'b0, size};
        if (nsel > 6'(N_LIM)) nsel = 6'(N_LIM);
    end

    always_comb begin
        state_next = state_reg;
        n_next = n_reg; i_next = i_reg; k_next = k_reg; back_next = back_reg;
        unique case (state_reg)
            ST_IDLE: if (solve_start && nsel != 0) begin
                n_next = nsel; back_next = back;
                i_next = back ? nsel - 6'd1 : 6'd0;
                k_next = 6'd0;
                state_next = ST_DIAG_RD;
            end
            ST_DIAG_RD: state_next = ST_DIAG_WT;
            ST_DIAG_WT: state_next = ST_DIV;
            ST_DIV:     state_next = ST_DIV_WB;
            ST_DIV_WB: if (!status.div_busy) begin
                k_next = 6'd0;
                if (back_reg) begin
                    if (i_reg == 0) state_next = ST_OUT_RD;
                    else state_next = ST_MAC_RD;
                end else if (i_reg == n_reg - 6'd1) begin
                    state_next = ST_OUT_RD;
                end else begin
                    i_next = i_reg + 6'd1;
                    state_next = ST_MAC_RD;
                end
            end
            ST_MAC_RD:  state_next = ST_MAC_WT;
            ST_MAC_WT:  state_next = ST_MAC_MUL;
            ST_MAC_MUL: state_next = ST_MAC_EXE;
            ST_MAC_EXE: begin
                k_next = k_reg + 6'd1;
                if (k_reg + 6'd1 == i_reg) begin
                    if (back_reg) i_next = i_reg - 6'd1;
                    state_next = ST_DIAG_RD;
                end else begin
                    state_next = ST_MAC_RD;
                end
            end
            ST_OUT_RD: if (!status.out_full) state_next = ST_OUT_WT;
            ST_OUT_WT: begin
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
                k_next = k_reg + 6'd1;
                state_next = (k_reg + 6'd1 == n_reg) ? ST_IDLE : ST_OUT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.rr = i_reg; cmd.cc = i_reg; cmd.vi = i_reg;
        cmd.fwd_sub = !back_reg;
        cmd.out_idx = k_reg;
        cmd.out_last = (k_reg + 6'd1 == n_reg);
        unique case (state_reg)
            ST_IDLE:    cmd.acc_clr = 1'b1;
            ST_DIAG_RD: cmd.rd = 1'b1;
            ST_DIV:     cmd.div_start = 1'b1;
            ST_DIV_WB:  if (!status.div_busy) begin
                cmd.div_wb = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_MAC_RD: begin
                // Backward steps scale x[i]; forward steps scale x[k].
                cmd.rd = 1'b1;
                cmd.rr = k_reg;
                cmd.vi = back_reg ? i_reg : k_reg;
            end
            ST_MAC_MUL: begin
                cmd.mul = 1'b1;
                // Backward steps fetch x[k] for the update while the product registers.
                if (back_reg) begin
                    cmd.rd = 1'b1;
                    cmd.rr = k_reg;
                    cmd.vi = k_reg;
                end
            end
            ST_MAC_EXE: begin
                cmd.vi = k_reg;
                cmd.mac_back = back_reg;
                cmd.mac_fwd = !back_reg;
            end
            ST_OUT_WT: cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
        n_reg <= n_next; i_reg <= i_next; k_reg <= k_next; back_reg <= back_next;
    end

    assign idle = (state_reg == ST_IDLE);

    `TSS_ASSERT_NEXT(a_div_follows, aclk, aresetn, state_reg == ST_DIV, state_reg == ST_DIV_WB,
        "divide not followed by write-back")
    `TSS_ASSERT_IMP(a_one_write, aclk, aresetn, 1'b1, !(cmd.div_wb && cmd.mac_back),
        "two vector writes in one cycle")
    `TSS_ASSERT_IMP(a_out_range, aclk, aresetn, cmd.out_load, k_reg < n_reg,
        "result index beyond system size")
endmodule

### tb/sv/triangular_system_solver_checker.sv
// ---------------------------------------------------------------------------
// triangular_system_solver_checker
// Watches the solver's channels, predicts each solution and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangular_system_solver_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tss_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tss_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_solutions
);
    import tss_pkg::*;

    logic signed [31:0] mat [16][16];
    logic signed [31:0] vec [16];
    logic [4:0]         size_reg;
    logic               backward;
    out_item_t          solution_queue [$];

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Arithmetic shift floors toward minus infinity.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clamp(p >>> 16);
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                                input logic signed [31:0] d,
                                                output logic zero);
        logic signed [63:0] num;
        zero = (d == 0);
        if (zero) begin
            if (a > 0) return 32'sh7FFFFFFF;
            if (a < 0) return 32'sh80000000;
            return 0;
        end
        num = 64'(a) <<< 16;
        return clamp(num / 64'(d));
    endfunction

    task automatic predict_solve();
        int n;
        logic zp [16];
        logic signed [31:0] t;
        out_item_t o;
        n = (size_reg > 16) ? 16 : size_reg;
        if (backward) begin
            for (int i = n - 1; i >= 0; i--) begin
                vec[i] = qdiv(vec[i], mat[i][i], zp[i]);
                for (int k = 0; k < i; k++)
                    vec[k] = clamp(64'(vec[k]) - 64'(qmul(vec[i], mat[k][i])));
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                t = 0;
                for (int k = 0; k < i; k++)
                    t = clamp(64'(t) + 64'(qmul(vec[k], mat[k][i])));
                vec[i] = qdiv(clamp(64'(vec[i]) - 64'(t)), mat[i][i], zp[i]);
            end
        end
        for (int i = 0; i < n; i++) begin
            o.index = 4'(i);
            o.solution = vec[i];
            o.zero_pivot = zp[i];
            o.last = (i == n - 1);
            solution_queue.push_back(o);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            size_reg <= 5'd16;
            backward <= 1'b1;
            fail_count <= 0;
            solution_queue.delete();
            pending_solutions <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SYSTEM_SIZE) size_reg <= cfg_data[4:0];
                else backward <= cfg_data[0];
            end
            if (s_valid && s_ready) begin
                case (kind_t'(s_data.kind))
                    KIND_MATRIX: mat[s_data.row][s_data.col] = s_data.value;
                    KIND_VECTOR: vec[s_data.row] = s_data.value;
                    KIND_SOLVE: predict_solve();
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (solution_queue.size() == 0) begin
                    $error("unexpected solution transaction index %0d", m_data.index);
                    errs++;
                end else begin
                    want = solution_queue.pop_front();
                    if (m_data.index !== want.index) begin
                        $error("index: expected %0d, got %0d", want.index, m_data.index);
                        errs++;
                    end
                    if (m_data.solution !== want.solution) begin
                        $error("solution: expected %h, got %h",
                               want.solution, m_data.solution);
                        errs++;
                    end
                    if (m_data.zero_pivot !== want.zero_pivot) begin
                        $error("zero_pivot: expected %b, got %b",
                               want.zero_pivot, m_data.zero_pivot);
                        errs++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_data.last);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            pending_solutions <= solution_queue.size();
        end
    end
endmodule

### tb/sv/triangular_system_solver_tb.sv
// ---------------------------------------------------------------------------
// triangular_system_solver_tb
// Stimulus and verdict for the triangular solver.
// ---------------------------------------------------------------------------
// Solves never go beyond size 8, and the upper triangle and right side of
// that size are written before the first solve, so no solve ever reads an
// unwritten word. Directed transactions cover the value extremes, zero
// pivots, both directions, sizes 1, 8 and zero, and kind 3; a random phase
// then mixes loads and solves. The checker beside the block predicts and
// compares every solution transaction.
`timescale 1ns / 1ps
module triangular_system_solver_tb;
    import tss_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = CFG_SYSTEM_SIZE;
    logic [31:0] cfg_data = '0;
    int         fail_count;
    int         pending_solutions;
    int         burst_left = 0;

    always #10 aclk = ~aclk;

    triangular_system_solver uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    triangular_system_solver_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_solutions(pending_solutions)
    );

    // The receiver stalls on its own pattern: long ready runs alternate with
    // patches of heavy back-pressure.
    always @(posedge aclk) begin
        int phase;
        phase = int'(($time / 20) % 400);
        if (phase < 120) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end

    // One transaction on the input channel. Gaps come between bursts of
    // random length, and valid stays high inside a burst.
    task automatic send_item(input kind_t k, input logic [3:0] r,
                             input logic [3:0] c, input logic [31:0] v);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        s_valid <= 1'b1;
        s_data <= '{kind: k, row: r, col: c, value: v};
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    // Waits until every solution is out, then lets the sequencer settle.
    task automatic drain();
        if (burst_left != 0) s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_solutions != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random Q16.16 value, mostly moderate so that solutions stay meaningful,
    // sometimes extreme.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
        endcase
    endfunction

    function automatic logic [31:0] rand_diag();
        if ($urandom_range(0, 15) == 0) return 32'h0;
        return ($urandom_range(0, 1) ? 32'h0 : 32'hFFFE0000)
               + 32'($urandom_range(32'h8000, 32'h1FFFF));
    endfunction

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(CFG_SYSTEM_SIZE, 32'd8);

        // Fill the upper triangle and the right side of size 8.
        for (int r = 0; r < 8; r++)
            for (int c = r; c < 8; c++)
                send_item(KIND_MATRIX, 4'(r), 4'(c), (r == c) ? 32'h00010000 : 32'h0);
        for (int r = 0; r < 8; r++)
            send_item(KIND_VECTOR, 4'(r), 4'd0, 32'h00010000 * r);

        // Directed: extremes, zero pivots of every dividend sign, kind 3.
        send_item(KIND_VECTOR, 4'd0, 4'd0, 32'h7FFFFFFF);
        send_item(KIND_VECTOR, 4'd1, 4'd0, 32'h80000000);
        send_item(KIND_VECTOR, 4'd2, 4'd0, 32'h0);
        send_item(KIND_MATRIX, 4'd1, 4'd1, 32'h0);
        send_item(KIND_MATRIX, 4'd2, 4'd2, 32'h0);
        send_item(KIND_MATRIX, 4'd3, 4'd3, 32'h0);
        send_item(KIND_MATRIX, 4'd0, 4'd7, 32'h80000000);
        send_item(KIND_MATRIX, 4'd6, 4'd7, 32'h7FFFFFFF);
        send_item(KIND_MATRIX, 4'd7, 4'd7, 32'h00000001);
        send_item(KIND_MATRIX, 4'd7, 4'd0, 32'hFFFFFFFF);
        send_item(KIND_NONE, 4'hF, 4'hF, 32'hFFFFFFFF);
        send_item(KIND_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();
        write_reg(CFG_BACK_SUBST, 32'h0);
        write_reg(CFG_SYSTEM_SIZE, 32'd1);
        send_item(KIND_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();
        write_reg(CFG_SYSTEM_SIZE, 32'd0);
        send_item(KIND_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();
        write_reg(CFG_SYSTEM_SIZE, 32'd8);
        send_item(KIND_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();

        // Random phase: each round picks a direction and a mostly small size,
        // reloads part of the system with random content and solves.
        for (int round = 0; round < 6; round++) begin
            int n;
            write_reg(CFG_BACK_SUBST, $urandom_range(0, 1));
            n = (round == 5) ? 8 : $urandom_range(1, 6);
            write_reg(CFG_SYSTEM_SIZE, n);
            for (int j = 0; j < 9; j++) begin
                int r;
                int c;
                r = $urandom_range(0, n - 1);
                c = $urandom_range(r, n - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2: send_item(KIND_VECTOR, 4'(r), 4'($urandom()), rand_value());
                    3:       send_item(KIND_MATRIX, 4'(r), 4'(r), rand_diag());
                    4:       send_item(KIND_NONE, 4'($urandom()), 4'($urandom()),
                                       $urandom());
                    5:       send_item(KIND_SOLVE, 4'($urandom()), 4'($urandom()),
                                       $urandom());
                    default: send_item(KIND_MATRIX, 4'(r), 4'(c),
                                       (r == c) ? rand_diag() : rand_value());
                endcase
            end
            send_item(KIND_SOLVE, 4'd0, 4'd0, 32'h0);
            // The sender holds off here until every solution has come back.
            drain();
        end

        drain();
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tss_pkg.sv
hw/rtl/tss_divider.sv
hw/rtl/tss_datapath.sv
hw/rtl/tss_controller.sv
hw/rtl/triangular_system_solver.sv
tb/sv/triangular_system_solver_checker.sv
tb/sv/triangular_system_solver_tb.sv
